// ===== hw/rtl/ofsl_pkg.sv =====
`default_nettype none
package ofsl_pkg;

	localparam int unsigned ADDR_W = 16;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned BYTE_W = 8;

	// section header words, as they appear big-endian in the stream
	localparam logic [WORD_W-1:0] HDR_CODE  = 16'hCADE;
	localparam logic [WORD_W-1:0] HDR_DATA  = 16'hDADA;
	localparam logic [WORD_W-1:0] HDR_SYM   = 16'hC3B7;
	localparam logic [WORD_W-1:0] HDR_FNAME = 16'hF17E;
	localparam logic [WORD_W-1:0] HDR_LINE  = 16'h715E;

	// a line section is three words that are skipped
	localparam logic [WORD_W-1:0] LINE_BYTES = 16'd6;

	localparam logic [2:0] KIND_NONE  = 3'd0;
	localparam logic [2:0] KIND_CODE  = 3'd1;
	localparam logic [2:0] KIND_DATA  = 3'd2;
	localparam logic [2:0] KIND_SYM   = 3'd3;
	localparam logic [2:0] KIND_FNAME = 3'd4;
	localparam logic [2:0] KIND_LINE  = 3'd5;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] mem_address;
		logic [WORD_W-1:0] mem_word;
		logic              from_data_section;
	} result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ofsl_in_if.sv =====
`default_nettype none
interface ofsl_in_if;
	logic                          valid;
	logic                          ready;
	logic [ofsl_pkg::BYTE_W-1:0]   in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ofsl_out_if.sv =====
`default_nettype none
interface ofsl_out_if;
	logic                          valid;
	logic                          ready;
	logic [ofsl_pkg::ADDR_W-1:0]   mem_address;
	logic [ofsl_pkg::WORD_W-1:0]   mem_word;
	logic                          from_data_section;

	modport source (output valid, output mem_address, output mem_word,
		output from_data_section, input ready);
	modport sink (input valid, input mem_address, input mem_word,
		input from_data_section, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ofsl_parser.sv =====
`default_nettype none
module ofsl_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	ofsl_in_if.sink            obj,
	input  wire logic          take,
	output ofsl_pkg::result_t  res
);

	localparam logic [3:0] PH_HDR_HI  = 4'd0;
	localparam logic [3:0] PH_HDR_LO  = 4'd1;
	localparam logic [3:0] PH_ADDR_HI = 4'd2;
	localparam logic [3:0] PH_ADDR_LO = 4'd3;
	localparam logic [3:0] PH_CNT_HI  = 4'd4;
	localparam logic [3:0] PH_CNT_LO  = 4'd5;
	localparam logic [3:0] PH_WORD_HI = 4'd6;
	localparam logic [3:0] PH_WORD_LO = 4'd7;
	localparam logic [3:0] PH_SKIP    = 4'd8;

	logic                          valid_s1;
	logic [ofsl_pkg::BYTE_W-1:0]   byte_s1;
	logic                          fire;

	logic [3:0]                    phase_q, phase_d;
	logic [2:0]                    kind_q, kind_d;
	logic [ofsl_pkg::BYTE_W-1:0]   held_q, held_d;
	logic [ofsl_pkg::ADDR_W-1:0]   addr_q, addr_d;
	logic [ofsl_pkg::WORD_W-1:0]   cnt_q, cnt_d;
	logic [ofsl_pkg::WORD_W-1:0]   joined;
	logic [ofsl_pkg::WORD_W-1:0]   cnt_dec;

	assign obj.ready = !valid_s1 || take;
	assign fire      = valid_s1 && take;
	assign joined    = {held_q, byte_s1};
	assign cnt_dec   = cnt_q - ofsl_pkg::WORD_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (obj.ready) begin
			valid_s1 <= obj.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (obj.valid && obj.ready) begin
			byte_s1 <= obj.in_byte;
		end
	end

	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		held_d  = held_q;
		addr_d  = addr_q;
		cnt_d   = cnt_q;
		res.valid             = 1'b0;
		res.mem_address       = addr_q;
		res.mem_word          = joined;
		res.from_data_section = (kind_q == ofsl_pkg::KIND_DATA);
		unique case (phase_q)
			PH_HDR_LO: begin
				if (joined == ofsl_pkg::HDR_CODE) begin
					kind_d  = ofsl_pkg::KIND_CODE;
					phase_d = PH_ADDR_HI;
				end else if (joined == ofsl_pkg::HDR_DATA) begin
					kind_d  = ofsl_pkg::KIND_DATA;
					phase_d = PH_ADDR_HI;
				end else if (joined == ofsl_pkg::HDR_SYM) begin
					kind_d  = ofsl_pkg::KIND_SYM;
					phase_d = PH_ADDR_HI;
				end else if (joined == ofsl_pkg::HDR_FNAME) begin
					kind_d  = ofsl_pkg::KIND_FNAME;
					phase_d = PH_CNT_HI;
				end else if (joined == ofsl_pkg::HDR_LINE) begin
					kind_d  = ofsl_pkg::KIND_LINE;
					cnt_d   = ofsl_pkg::LINE_BYTES;
					phase_d = PH_SKIP;
				end else begin
					kind_d  = ofsl_pkg::KIND_NONE;
					phase_d = PH_HDR_HI;
				end
			end
			PH_ADDR_HI: begin
				held_d  = byte_s1;
				phase_d = PH_ADDR_LO;
			end
			PH_ADDR_LO: begin
				addr_d  = joined;
				phase_d = PH_CNT_HI;
			end
			PH_CNT_HI: begin
				held_d  = byte_s1;
				phase_d = PH_CNT_LO;
			end
			PH_CNT_LO: begin
				cnt_d = joined;
				if (joined == '0) begin
					phase_d = PH_HDR_HI;
				end else if (kind_q == ofsl_pkg::KIND_CODE ||
						kind_q == ofsl_pkg::KIND_DATA) begin
					phase_d = PH_WORD_HI;
				end else begin
					phase_d = PH_SKIP;
				end
			end
			PH_WORD_HI: begin
				held_d  = byte_s1;
				phase_d = PH_WORD_LO;
			end
			PH_WORD_LO: begin
				res.valid = valid_s1;
				addr_d    = addr_q + ofsl_pkg::ADDR_W'(1);
				cnt_d     = cnt_dec;
				phase_d   = (cnt_dec == '0) ? PH_HDR_HI : PH_WORD_HI;
			end
			PH_SKIP: begin
				cnt_d = cnt_dec;
				if (cnt_dec == '0) begin
					phase_d = PH_HDR_HI;
				end
			end
			default: begin
				// header high byte, also where unused phase codes land
				held_d  = byte_s1;
				phase_d = PH_HDR_LO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR_HI;
			kind_q  <= ofsl_pkg::KIND_NONE;
			held_q  <= '0;
			addr_q  <= '0;
			cnt_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			held_q  <= held_d;
			addr_q  <= addr_d;
			cnt_q   <= cnt_d;
		end
	end

`ifndef ASSERT_OFF
	a_addr_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == PH_WORD_LO |=> addr_q == $past(addr_q) + 16'd1)
		else $error("write address did not advance after a data word");

	a_skip_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == PH_SKIP && cnt_q == 16'd1 |=> phase_q == PH_HDR_HI)
		else $error("skip did not end at a header");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !take |=> valid_s1 && $stable(byte_s1))
		else $error("stalled input byte lost");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !take |=> res.valid && $stable(res.mem_address) &&
			$stable(res.mem_word))
		else $error("stalled write lost");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/ofsl_out_reg.sv =====
`default_nettype none
module ofsl_out_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  ofsl_pkg::result_t  res,
	output logic               take,
	ofsl_out_if.source         mem
);

	logic                          valid_q;
	logic [ofsl_pkg::ADDR_W-1:0]   addr_q;
	logic [ofsl_pkg::WORD_W-1:0]   word_q;
	logic                          data_q;

	// stage may be refilled in the same cycle its word leaves
	assign take = !valid_q || mem.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res.valid) begin
			addr_q <= res.mem_address;
			word_q <= res.mem_word;
			data_q <= res.from_data_section;
		end
	end

	assign mem.valid             = valid_q;
	assign mem.mem_address       = addr_q;
	assign mem.mem_word          = word_q;
	assign mem.from_data_section = data_q;

endmodule
`default_nettype wire

// ===== hw/rtl/object_file_section_loader_top.sv =====
`default_nettype none
// Object-file section loader. Takes the file one byte per transfer on obj and
// issues one memory write on mem for every data word of a code (0xCADE) or
// data (0xDADA) section, at the section's running address, which wraps at
// 16 bits. Symbol, filename and line sections are skipped; unknown header
// words are dropped. One byte is taken every cycle unless a write is stalled:
// a byte waits in the input register while the parser decodes it, and the
// resulting write is registered in the output register, which drives mem.
// The only stall comes from mem.ready held low while a write is pending.
module object_file_section_loader_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ofsl_in_if.sink     obj,
	ofsl_out_if.source  mem
);

	ofsl_pkg::result_t  res;
	logic               take;

	ofsl_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.obj    (obj),
		.take   (take),
		.res    (res)
	);

	ofsl_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.take   (take),
		.mem    (mem)
	);

endmodule
`default_nettype wire
